@@ design/circle_span_rasterizer_assert.svh @@
// Assertion macros used by the top level of the circle span rasterizer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CIRCLE_SPAN_RASTERIZER_ASSERT_SVH
`define CIRCLE_SPAN_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/crs_pkg.sv @@
// Package for the circle span rasterizer: payload structs, control word format,
// configuration codes and the microcode ROM. No dependencies.
package crs_pkg;

  localparam int COORD_BITS = 10;
  localparam int CFG_W      = 11;
  localparam int PC_W       = 4;

  localparam logic [CFG_W-1:0] SCREEN_LIMIT     = CFG_W'(1 << COORD_BITS);
  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 11'd240;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 11'd160;
  localparam logic [CFG_W-1:0] RST_LINE_STRIDE   = 11'd240;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LINE_STRIDE   = 2'd2;

  localparam logic [PC_W-1:0] PC_DISPATCH   = 4'd0;
  localparam logic [PC_W-1:0] PC_FILL_ENTRY = 4'd9;

  typedef struct packed {
    logic        func;
    logic [9:0]  center_x;
    logic [9:0]  center_y;
    logic [9:0]  radius;
    logic [15:0] pixel_color;
    logic        fill_mode;
  } crs_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [9:0]  row;
    logic [9:0]  span_start;
    logic [9:0]  span_end;
    logic [19:0] pixel_address;
    logic [15:0] out_color;
    logic        step_last;
    logic        circle_done;
  } crs_out_t;

  typedef enum logic [1:0] {
    OP_NEXT,
    OP_JFILL,
    OP_END
  } seq_op_t;

  // Offset applied to a centre coordinate.
  typedef enum logic [1:0] {
    OFF_PLUS_B,
    OFF_MINUS_B,
    OFF_PLUS_A,
    OFF_MINUS_A
  } off_sel_t;

  typedef struct packed {
    seq_op_t         op;
    logic            emit;
    off_sel_t        row_sel;
    off_sel_t        lo_sel;
    off_sel_t        hi_sel;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic     emit;
    logic     last;
    off_sel_t row_sel;
    off_sel_t lo_sel;
    off_sel_t hi_sel;
  } seq_ctl_t;

  // Circle status from the datapath to the sequencer and the top level.
  typedef struct packed {
    logic active;
    logic fill;
  } crs_status_t;

  // One clipped span between the datapath and the address stage.
  typedef struct packed {
    logic        valid;
    logic        we;
    logic [9:0]  row;
    logic [9:0]  sx;
    logic [9:0]  ex;
    logic [15:0] color;
    logic        last;
    logic        done;
  } span_t;

  function automatic ctl_word_t mk_word(input seq_op_t op, input logic emit,
                                        input off_sel_t r, input off_sel_t lo,
                                        input off_sel_t hi, input logic [PC_W-1:0] tgt);
    ctl_word_t w;
    w.op      = op;
    w.emit    = emit;
    w.row_sel = r;
    w.lo_sel  = lo;
    w.hi_sel  = hi;
    w.target  = tgt;
    return w;
  endfunction

  // Outline program runs from the word after dispatch, the fill program from its entry.
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    case (pc)
      4'd0:    w = mk_word(OP_JFILL, 1'b0, OFF_PLUS_B, OFF_PLUS_A, OFF_PLUS_A, PC_FILL_ENTRY);
      4'd1:    w = mk_word(OP_NEXT, 1'b1, OFF_PLUS_B, OFF_PLUS_A, OFF_PLUS_A, PC_DISPATCH);
      4'd2:    w = mk_word(OP_NEXT, 1'b1, OFF_PLUS_B, OFF_MINUS_A, OFF_MINUS_A, PC_DISPATCH);
      4'd3:    w = mk_word(OP_NEXT, 1'b1, OFF_MINUS_B, OFF_PLUS_A, OFF_PLUS_A, PC_DISPATCH);
      4'd4:    w = mk_word(OP_NEXT, 1'b1, OFF_MINUS_B, OFF_MINUS_A, OFF_MINUS_A, PC_DISPATCH);
      4'd5:    w = mk_word(OP_NEXT, 1'b1, OFF_PLUS_A, OFF_PLUS_B, OFF_PLUS_B, PC_DISPATCH);
      4'd6:    w = mk_word(OP_NEXT, 1'b1, OFF_PLUS_A, OFF_MINUS_B, OFF_MINUS_B, PC_DISPATCH);
      4'd7:    w = mk_word(OP_NEXT, 1'b1, OFF_MINUS_A, OFF_PLUS_B, OFF_PLUS_B, PC_DISPATCH);
      4'd8:    w = mk_word(OP_END, 1'b1, OFF_MINUS_A, OFF_MINUS_B, OFF_MINUS_B, PC_DISPATCH);
      4'd9:    w = mk_word(OP_NEXT, 1'b1, OFF_PLUS_B, OFF_MINUS_A, OFF_PLUS_A, PC_DISPATCH);
      4'd10:   w = mk_word(OP_NEXT, 1'b1, OFF_MINUS_B, OFF_MINUS_A, OFF_PLUS_A, PC_DISPATCH);
      4'd11:   w = mk_word(OP_NEXT, 1'b1, OFF_PLUS_A, OFF_MINUS_B, OFF_PLUS_B, PC_DISPATCH);
      4'd12:   w = mk_word(OP_END, 1'b1, OFF_MINUS_A, OFF_MINUS_B, OFF_PLUS_B, PC_DISPATCH);
      default: w = mk_word(OP_END, 1'b0, OFF_PLUS_B, OFF_PLUS_B, OFF_PLUS_B, PC_DISPATCH);
    endcase
    return w;
  endfunction

endpackage

@@ design/circle_span_rasterizer.sv @@
// Top level of the midpoint circle span rasterizer: configuration registers
// and the sequencer, datapath and address stage. Depends on crs_pkg.
//
// Usage. An item is transferred when start is high and busy is low. A start
// item (func 0) loads centre, radius, colour and fill mode and gives no
// result; a radius below 3 leaves no circle to draw. A step item (func 1)
// runs one iteration of the decision loop and gives eight outline pixels or
// four fill spans; a step with no circle loaded is dropped. A step holds
// busy through one dispatch word of the microcode program and then one word
// per result, so the ROM program sets the rate at one result per cycle. The
// first result follows the dispatch word through a clipping register and an
// address register. Each result is shown for one cycle with out_valid high;
// the receiver cannot stall. step_last marks the last result of a step and
// circle_done marks every result of the step that ends the circle.
// cfg_we writes cfg_data into the register named by cfg_index at once; write
// only while idle. Synchronous reset restores the default screen size and
// stride and clears the circle.
`include "circle_span_rasterizer_assert.svh"

module circle_span_rasterizer
  import crs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  crs_in_t          in_data,
  output logic             out_valid,
  output crs_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] screen_width_r, screen_height_r, line_stride_r;
  logic             accept, load, step_go, running;
  seq_ctl_t         ctl;
  crs_status_t      status;
  span_t            span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      line_stride_r   <= RST_LINE_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        CFG_LINE_STRIDE:   line_stride_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept  = start && !running;
  assign load    = accept && (in_data.func == FUNC_START);
  assign step_go = accept && (in_data.func == FUNC_STEP) && status.active;
  assign busy    = running;

  crs_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_go (step_go),
    .status  (status),
    .ctl     (ctl),
    .running (running)
  );

  crs_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .in_item       (in_data),
    .ctl           (ctl),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .status        (status),
    .span          (span)
  );

  crs_addr_stage u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .span        (span),
    .line_stride (line_stride_r),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  `CRS_ASSERT_IMPL(a_dropped_zero, out_valid && !out_data.write_enable,
                   (out_data.row == 10'd0) && (out_data.span_start == 10'd0) &&
                   (out_data.pixel_address == 20'd0) && (out_data.out_color == 16'd0),
                   "dropped result carries non-zero fields")
  `CRS_ASSERT_NEXT(a_gap_after_last, out_valid && out_data.step_last, !out_valid,
                   "result follows the last result of a step without a gap")
  `CRS_ASSERT_IMPL(a_span_order, out_valid && out_data.write_enable,
                   out_data.span_start <= out_data.span_end,
                   "written span ends before it starts")

endmodule

@@ design/crs_sequencer.sv @@
// Microcode sequencer: step counter, ROM lookup and conditional jump.
// Depends on crs_pkg.
module crs_sequencer
  import crs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_go,
  input  crs_status_t status,
  output seq_ctl_t    ctl,
  output logic        running
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            running_r, running_nxt;
  ctl_word_t       word;

  assign word = ucode_rom(pc_r);

  always_comb begin
    pc_nxt      = pc_r;
    running_nxt = running_r;
    if (step_go) begin
      pc_nxt      = PC_DISPATCH;
      running_nxt = 1'b1;
    end else if (running_r) begin
      case (word.op)
        OP_NEXT:  pc_nxt = pc_r + PC_W'(1);
        OP_JFILL: pc_nxt = status.fill ? word.target : pc_r + PC_W'(1);
        OP_END:   running_nxt = 1'b0;
        default:  running_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= PC_DISPATCH;
      running_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      running_r <= running_nxt;
    end
  end

  always_comb begin
    ctl.emit    = running_r && word.emit;
    ctl.last    = running_r && (word.op == OP_END);
    ctl.row_sel = word.row_sel;
    ctl.lo_sel  = word.lo_sel;
    ctl.hi_sel  = word.hi_sel;
  end

  assign running = running_r;

endmodule

@@ design/crs_datapath.sv @@
// Circle state, midpoint decision update and span generation with clipping.
// Depends on crs_pkg; driven by the control of crs_sequencer.
module crs_datapath
  import crs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  crs_in_t          in_item,
  input  seq_ctl_t         ctl,
  input  logic [CFG_W-1:0] screen_width,
  input  logic [CFG_W-1:0] screen_height,
  output crs_status_t      status,
  output span_t            span
);

  logic [9:0]  center_col_r, center_row_r;
  logic [15:0] draw_color_r;
  logic        fill_flag_r, active_r;
  logic [10:0] offset_minor_r, offset_major_r;
  logic [15:0] decision_r;

  logic        d_pos, done;
  logic [15:0] diff, inc, decision_upd;
  logic [10:0] minor_upd, major_upd;

  logic [CFG_W-1:0]   w_eff, h_eff;
  logic signed [11:0] a_s, b_s, row_c, x_lo, x_hi, sx, ex, wm1;
  logic               row_ok, we;
  span_t              span_r;

  function automatic logic signed [11:0] apply_off(input logic [9:0] base,
                                                   input off_sel_t sel,
                                                   input logic signed [11:0] a,
                                                   input logic signed [11:0] b);
    logic signed [11:0] c;
    c = $signed({2'b00, base});
    case (sel)
      OFF_PLUS_B:  return c + b;
      OFF_MINUS_B: return c - b;
      OFF_PLUS_A:  return c + a;
      OFF_MINUS_A: return c - a;
      default:     return c;
    endcase
  endfunction

  // Decision update for the current iteration; the stored state moves on the last word.
  always_comb begin
    d_pos        = ($signed(decision_r) > 16'sd0);
    diff         = {5'b0, offset_minor_r} - {5'b0, offset_major_r};
    inc          = d_pos ? ({diff[13:0], 2'b00} + 16'd10)
                         : ({3'b0, offset_minor_r, 2'b00} + 16'd6);
    decision_upd = decision_r + inc;
    minor_upd    = offset_minor_r + 11'd1;
    major_upd    = d_pos ? (offset_major_r - 11'd1) : offset_major_r;
    done         = (major_upd < minor_upd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r   <= '0;
      center_row_r   <= '0;
      draw_color_r   <= '0;
      fill_flag_r    <= 1'b0;
      offset_minor_r <= '0;
      offset_major_r <= '0;
      decision_r     <= '0;
      active_r       <= 1'b0;
    end else if (load) begin
      center_col_r   <= in_item.center_x;
      center_row_r   <= in_item.center_y;
      draw_color_r   <= in_item.pixel_color;
      fill_flag_r    <= in_item.fill_mode;
      offset_minor_r <= '0;
      offset_major_r <= {1'b0, in_item.radius};
      decision_r     <= 16'd3 - {5'b0, in_item.radius, 1'b0};
      active_r       <= (in_item.radius >= 10'd3);
    end else if (ctl.last) begin
      offset_minor_r <= minor_upd;
      offset_major_r <= major_upd;
      decision_r     <= decision_upd;
      active_r       <= !done;
    end
  end

  // Span coordinates and clipping against the visible area.
  always_comb begin
    w_eff  = (screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width;
    h_eff  = (screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height;
    a_s    = $signed({1'b0, offset_minor_r});
    b_s    = $signed({1'b0, offset_major_r});
    row_c  = apply_off(center_row_r, ctl.row_sel, a_s, b_s);
    x_lo   = apply_off(center_col_r, ctl.lo_sel, a_s, b_s);
    x_hi   = apply_off(center_col_r, ctl.hi_sel, a_s, b_s);
    wm1    = $signed({1'b0, w_eff}) - 12'sd1;
    row_ok = (row_c >= 12'sd0) && (row_c < $signed({1'b0, h_eff}));
    sx     = x_lo[11] ? 12'sd0 : x_lo;
    ex     = (x_hi > wm1) ? wm1 : x_hi;
    we     = row_ok && (sx <= ex);
  end

  // Only the valid flag is reset; the payload loads whenever a word emits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r.valid <= 1'b0;
    end else begin
      span_r.valid <= ctl.emit;
    end
    if (ctl.emit) begin
      span_r.we    <= we;
      span_r.row   <= row_c[9:0];
      span_r.sx    <= sx[9:0];
      span_r.ex    <= ex[9:0];
      span_r.color <= draw_color_r;
      span_r.last  <= ctl.last;
      span_r.done  <= done;
    end
  end

  assign span          = span_r;
  assign status.active = active_r;
  assign status.fill   = fill_flag_r;

endmodule

@@ design/crs_addr_stage.sv @@
// Output stage: frame-buffer address multiply-add and the result register.
// Depends on crs_pkg.
module crs_addr_stage
  import crs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  span_t            span,
  input  logic [CFG_W-1:0] line_stride,
  output logic             out_valid,
  output crs_out_t         out_data
);

  logic [20:0] prod;
  logic [20:0] addr_sum;
  logic        valid_r;
  crs_out_t    data_r;

  assign prod     = {11'b0, span.row} * {10'b0, line_stride};
  assign addr_sum = prod + {11'b0, span.sx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= span.valid;
    end
  end

  // A dropped result carries zero fields apart from its two flags.
  always_ff @(posedge clk) begin
    if (span.valid) begin
      data_r.write_enable  <= span.we;
      data_r.row           <= span.we ? span.row : '0;
      data_r.span_start    <= span.we ? span.sx : '0;
      data_r.span_end      <= span.we ? span.ex : '0;
      data_r.pixel_address <= span.we ? addr_sum[19:0] : '0;
      data_r.out_color     <= span.we ? span.color : '0;
      data_r.step_last     <= span.last;
      data_r.circle_done   <= span.done;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for circle_span_rasterizer: predicts each frame-buffer write of the
// midpoint circle loop and checks every strobed result. Depends on crs_pkg.
module tb;
  import crs_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 400_000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  crs_in_t          in_data;
  logic             out_valid;
  crs_out_t         out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Predicted registers and circle state.
  logic [CFG_W-1:0]   m_width    = RST_SCREEN_WIDTH;
  logic [CFG_W-1:0]   m_height   = RST_SCREEN_HEIGHT;
  logic [CFG_W-1:0]   m_stride   = RST_LINE_STRIDE;
  logic [9:0]         m_col      = '0;
  logic [9:0]         m_row      = '0;
  logic [15:0]        m_color    = '0;
  logic               m_fill     = 1'b0;
  logic [10:0]        m_minor    = '0;
  logic [10:0]        m_major    = '0;
  logic signed [15:0] m_decision = '0;
  logic               m_active   = 1'b0;

  crs_out_t pending_writes[$];
  int error_count    = 0;
  int writes_checked = 0;
  int starts_sent    = 0;
  int steps_sent     = 0;
  int settings_used  = 1;
  int burst_left     = 0;

  circle_span_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int visible(input logic [CFG_W-1:0] size);
    return (size > SCREEN_LIMIT) ? int'(SCREEN_LIMIT) : int'(size);
  endfunction

  function automatic crs_in_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return crs_in_t'(raw[$bits(crs_in_t)-1:0]);
  endfunction

  // One span or pixel after clipping; anything off screen becomes a null write.
  function automatic crs_out_t clip_write(input int row, input int x1, input int x2,
                                          input bit last, input bit done);
    crs_out_t w;
    int wd, ht, sx, ex;
    w = '0;
    w.step_last = last;
    w.circle_done = done;
    wd = visible(m_width);
    ht = visible(m_height);
    if (row < 0 || row >= ht) return w;
    sx = (x1 < 0) ? 0 : x1;
    ex = (x2 > wd - 1) ? wd - 1 : x2;
    if (sx > ex) return w;
    w.write_enable  = 1'b1;
    w.row           = 10'(row);
    w.span_start    = 10'(sx);
    w.span_end      = 10'(ex);
    w.pixel_address = 20'(row * int'(m_stride) + sx);
    w.out_color     = m_color;
    return w;
  endfunction

  task automatic compute_writes(input crs_in_t item);
    int cx, cy, a, b, d, n;
    int rows[8], los[8], his[8];
    bit done;
    if (item.func == FUNC_START) begin
      starts_sent++;
      m_col      = item.center_x;
      m_row      = item.center_y;
      m_color    = item.pixel_color;
      m_fill     = item.fill_mode;
      m_minor    = '0;
      m_major    = {1'b0, item.radius};
      m_decision = 16'(3 - 2 * int'(item.radius));
      m_active   = (item.radius >= 3);
      return;
    end
    steps_sent++;
    if (!m_active) return;
    cx = int'(m_col);
    cy = int'(m_row);
    a  = int'(m_minor);
    b  = int'(m_major);
    if (m_fill) begin
      rows = '{cy + b, cy - b, cy + a, cy - a, 0, 0, 0, 0};
      los  = '{cx - a, cx - a, cx - b, cx - b, 0, 0, 0, 0};
      his  = '{cx + a, cx + a, cx + b, cx + b, 0, 0, 0, 0};
      n = 4;
    end else begin
      rows = '{cy + b, cy + b, cy - b, cy - b, cy + a, cy + a, cy - a, cy - a};
      los  = '{cx + a, cx - a, cx + a, cx - a, cx + b, cx - b, cx + b, cx - b};
      his  = los;
      n = 8;
    end
    d = int'(m_decision);
    if (d <= 0) begin
      d = d + 4 * a + 6;
    end else begin
      d = d + 4 * (a - b) + 10;
      b = b - 1;
    end
    a = a + 1;
    m_decision = 16'(d);
    m_minor    = 11'(a);
    m_major    = 11'(b);
    done = (b < a);
    if (done) m_active = 1'b0;
    for (int k = 0; k < n; k++) begin
      pending_writes.push_back(clip_write(rows[k], los[k], his[k], k == n - 1, done));
    end
  endtask

  function automatic string fmt_write(input crs_out_t w);
    return $sformatf("we=%0d row=%0d start=%0d end=%0d addr=%0d colour=%h last=%0d done=%0d",
                     w.write_enable, w.row, w.span_start, w.span_end, w.pixel_address,
                     w.out_color, w.step_last, w.circle_done);
  endfunction

  task automatic check_write(input crs_out_t got);
    crs_out_t want;
    if (pending_writes.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("%0t: write with none expected: %s", $time, fmt_write(got));
      return;
    end
    want = pending_writes.pop_front();
    writes_checked++;
    if (got.write_enable !== want.write_enable || got.row !== want.row ||
        got.span_start !== want.span_start || got.span_end !== want.span_end ||
        got.pixel_address !== want.pixel_address || got.out_color !== want.out_color ||
        got.step_last !== want.step_last || got.circle_done !== want.circle_done) begin
      error_count++;
      if (error_count <= 10) begin
        $display("%0t: write mismatch\n  expected %s\n  actual   %s",
                 $time, fmt_write(want), fmt_write(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) check_write(out_data);
  end

  // Start stays high after a transfer so that the next item can follow at once.
  task automatic send_item(input crs_in_t item);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_writes(item);
  endtask

  // The sender works in bursts; between bursts it usually idles for a while.
  task automatic issue(input crs_in_t item);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start   <= 1'b0;
        in_data <= random_item();
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_item(item);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(posedge clk);
    // A start transfer gives no result, so allow the block to settle as well.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic start_circle(input logic [9:0] x, input logic [9:0] y, input logic [9:0] r,
                              input logic [15:0] colour, input logic fill);
    crs_in_t item;
    item = random_item();
    item.func        = FUNC_START;
    item.center_x    = x;
    item.center_y    = y;
    item.radius      = r;
    item.pixel_color = colour;
    item.fill_mode   = fill;
    issue(item);
  endtask

  task automatic step_circle(input int count);
    crs_in_t item;
    for (int i = 0; i < count; i++) begin
      item = random_item();
      item.func = FUNC_STEP;
      issue(item);
    end
  endtask

  function automatic logic [9:0] pick_coord(input int extent);
    int v;
    case ($urandom_range(0, 2))
      0:       v = $urandom_range(0, 1023);
      1:       v = $urandom_range(0, 24);
      default: v = extent + int'($urandom_range(0, 48)) - 24;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  // Steps with nothing loaded, and radii too small to draw anything.
  task automatic test_idle_steps();
    step_circle(1);
    for (int r = 0; r < 3; r++) begin
      start_circle(10'd100, 10'd80, 10'(r), 16'h1234, r[0]);
      step_circle(1);
    end
  endtask

  // The smallest live radius in both modes, each run to the end; the fill circle gets one step past it.
  task automatic test_small_circles();
    start_circle(10'd5, 10'd5, 10'd3, 16'h0000, 1'b0);
    step_circle(3);
    start_circle(10'd0, 10'd0, 10'd3, 16'hFFFF, 1'b1);
    step_circle(4);
  endtask

  // Extreme centres and radius; each circle is cut short by the next start.
  task automatic test_far_corners();
    start_circle(10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b0);
    step_circle(2);
    start_circle(10'd1023, 10'd0, 10'd1023, 16'h5A5A, 1'b1);
    step_circle(2);
    start_circle(10'd0, 10'd1023, 10'd21, 16'h0001, 1'b0);
    step_circle(2);
  endtask

  // Mostly whole circles with random content; some are cut short or padded with
  // stray items. Ignored steps do not count against the budget.
  task automatic test_random_circles(input int budget);
    crs_in_t item;
    int used, steps;
    bit live;
    used = 0;
    while (used < budget) begin
      item = random_item();
      if ($urandom_range(0, 7) == 0) begin
        live = (item.func == FUNC_START) || m_active;
        issue(item);
        used += live;
      end else begin
        item.func     = FUNC_START;
        item.center_x = pick_coord(visible(m_width));
        item.center_y = pick_coord(visible(m_height));
        case ($urandom_range(0, 9))
          7, 8:    item.radius = 10'($urandom_range(21, 80));
          9:       item.radius = 10'($urandom_range(81, 1023));
          default: item.radius = 10'($urandom_range(0, 20));
        endcase
        issue(item);
        used++;
        steps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : budget;
        while (m_active && steps > 0 && used < budget) begin
          step_circle(1);
          used++;
          steps--;
        end
        if (!m_active && $urandom_range(0, 3) == 0) step_circle(1);
      end
    end
  endtask

  // All registers are written back to back while the block is idle.
  task automatic test_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] s, input int budget);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_LINE_STRIDE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_width  = w;
    m_height = h;
    m_stride = s;
    settings_used++;
    test_random_circles(budget);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_steps();
    test_small_circles();
    test_far_corners();
    test_random_circles(60);
    test_setting(11'd1, 11'd1, 11'd1, 60);
    test_setting(11'd1024, 11'd1024, 11'd1024, 60);
    test_setting(11'd2047, 11'd2047, 11'd2047, 60);
    test_setting(11'd0, 11'd512, 11'd1, 30);
    test_setting(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                 11'($urandom_range(1, 1024)), 60);
    drain();

    $display("Sent %0d circle starts and %0d steps under %0d screen settings.",
             starts_sent, steps_sent, settings_used);
    $display("Checked %0d frame-buffer writes; %0d mismatches.", writes_checked, error_count);
    if (error_count == 0 && pending_writes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d writes still expected.", pending_writes.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
